/* rtl/itoa_pkg.sv */
package itoa_pkg;

  localparam int ACTION_W = 3;
  localparam int IN_VALUE_W = 32;
  localparam int CHAR_W = 8;

  localparam logic [ACTION_W-1:0] ACT_CHAR = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SDEC = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UDEC = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_OCT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_HEX  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [IN_VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } out_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    unique case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      4'hF: c = 8'h46;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

/* rtl/integer_to_ascii_formatter.sv */
// channel   signals                         transaction when
// command   start, busy, cmd (in_t)         start high and busy low at clk rise
// result    strobe, result (out_t)          every cycle with strobe high
//
// char mode: the character, then the closing space; unknown action: only the closing space.
// octal and hex: NDIG digit slots of the shift register
// (11 at VALUE_WIDTH 32), leading zero slots are skipped one per cycle.
// decimal: the shift-add-3 unit takes one bit per cycle before the digits are emitted.
// rst is synchronous and clears the sequencer and the strobe; the receiver cannot stall.
module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  itoa_pkg::in_t      cmd,
  output logic               strobe,
  output itoa_pkg::out_t     result
);

  localparam int W = VALUE_WIDTH;
  localparam int NDEC = (W * 30103) / 100000 + 1;
  localparam int NOCT = (W + 2) / 3;
  localparam int NDIG = (NOCT > NDEC) ? NOCT : NDEC;
  localparam int DW = NDIG * 4;
  localparam int XW = (W > itoa_pkg::IN_VALUE_W) ? W : itoa_pkg::IN_VALUE_W;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_EMIT,
    ST_SPACE
  } state_t;

  state_t          state;
  logic [DW-1:0]   dig;
  logic [W-1:0]    sh;
  logic [CW-1:0]   cnt;
  logic            lead;

  logic [XW-1:0]       vx;
  logic [W-1:0]        v;
  logic                neg;
  logic [W-1:0]        mag;
  logic [NDIG*3-1:0]   v3;
  logic [DW-1:0]       oct_dig;
  logic [DW-1:0]       adj;
  logic [3:0]          top;

  assign busy = (state != ST_IDLE);
  assign vx   = XW'(cmd.value);
  assign v    = vx[W-1:0];
  assign neg  = (cmd.action == itoa_pkg::ACT_SDEC) && v[W-1];
  assign mag  = neg ? (~v + W'(1)) : v;
  assign v3   = (NDIG*3)'(v);
  assign top  = dig[DW-1 -: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      oct_dig[4*i +: 4] = {1'b0, v3[3*i +: 3]};
    end
  end

  // shift-add-3 correction per bcd digit
  always_comb begin
    adj = dig;
    for (int i = 0; i < NDIG; i++) begin
      if (dig[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      lead   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            unique case (cmd.action)
              itoa_pkg::ACT_CHAR: begin
                strobe <= 1'b1;
                result <= '{char_out: cmd.value[7:0], last: 1'b0};
                state  <= ST_SPACE;
              end
              itoa_pkg::ACT_SDEC, itoa_pkg::ACT_UDEC: begin
                if (neg) begin
                  strobe <= 1'b1;
                  result <= '{char_out: itoa_pkg::CH_MINUS, last: 1'b0};
                end
                sh    <= mag;
                dig   <= '0;
                cnt   <= CW'(W);
                state <= ST_DABBLE;
              end
              itoa_pkg::ACT_OCT: begin
                dig   <= oct_dig;
                cnt   <= CW'(NDIG);
                lead  <= 1'b1;
                state <= ST_EMIT;
              end
              itoa_pkg::ACT_HEX: begin
                dig   <= DW'(v);
                cnt   <= CW'(NDIG);
                lead  <= 1'b1;
                state <= ST_EMIT;
              end
              default: begin
                strobe <= 1'b1;
                result <= '{char_out: itoa_pkg::CH_SPACE, last: 1'b1};
              end
            endcase
          end
        end
        ST_DABBLE: begin
          dig <= {adj[DW-2:0], sh[W-1]};
          sh  <= {sh[W-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            cnt   <= CW'(NDIG);
            lead  <= 1'b1;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          dig <= {dig[DW-5:0], 4'h0};
          cnt <= cnt - CW'(1);
          if (!(lead && top == 4'h0 && cnt != CW'(1))) begin
            strobe <= 1'b1;
            result <= '{char_out: itoa_pkg::hex_char(top), last: 1'b0};
            lead   <= 1'b0;
            if (cnt == CW'(1)) begin
              state <= ST_SPACE;
            end
          end
        end
        ST_SPACE: begin
          strobe <= 1'b1;
          result <= '{char_out: itoa_pkg::CH_SPACE, last: 1'b1};
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/itoa_checker.sv */
module itoa_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           strobe,
  input itoa_pkg::out_t result
);

  // closing space only shows once the block is free again
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy)
    else $error("closing space shown while busy");

  // any other character belongs to a transaction still in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("non-final character shown while idle");

  // an accepted command keeps the block busy or closes at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || (strobe && result.last))
    else $error("accepted command produced nothing");

  // leaving busy always comes with the closing space
  a_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> strobe && result.last)
    else $error("busy dropped without closing space");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
